@@ rtl/core/lss_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types, register map, weight table and constants of the liveness
// score smoother.
// ----------------------------------------------------------------------------
package lss_pkg;

	// default sizes
	localparam int HISTORY_DEPTH_DEF = 8;
	localparam int SCORE_BITS_DEF    = 16;

	// register file geometry
	localparam int REG_BITS     = 16;
	localparam int REG_IDX_BITS = 3;
	localparam int LIMIT_BITS   = 2;
	localparam int RUN_BITS     = 2;

	// weights are Q12, largest entry fits 13 bits
	localparam int WEIGHT_BITS    = 13;
	localparam int WEIGHT_ENTRIES = 120;

	// blend (7*raw + 3*avg + 5) / 10
	localparam int BLEND_RAW_W = 7;
	localparam int BLEND_AVG_W = 3;
	localparam int BLEND_ROUND = 5;
	localparam int BLEND_DEN   = 10;

	// register indexes
	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_FAKE_CUT        = 3'd0,
		REG_SWAP_PREV_HIGH  = 3'd1,
		REG_SWAP_CUR_LOW    = 3'd2,
		REG_LOW_CUT         = 3'd3,
		REG_LOW_RUN_LIMIT   = 3'd4,
		REG_DROP_GAP        = 3'd5,
		REG_REAL_THRESHOLD  = 3'd6,
		REG_SPOOF_THRESHOLD = 3'd7
	} reg_idx_t;

	// register reset values
	localparam logic [REG_BITS-1:0]   RST_FAKE_CUT        = 16'd16384;
	localparam logic [REG_BITS-1:0]   RST_SWAP_PREV_HIGH  = 16'd45875;
	localparam logic [REG_BITS-1:0]   RST_SWAP_CUR_LOW    = 16'd29491;
	localparam logic [REG_BITS-1:0]   RST_LOW_CUT         = 16'd26214;
	localparam logic [LIMIT_BITS-1:0] RST_LOW_RUN_LIMIT   = 2'd3;
	localparam logic [REG_BITS-1:0]   RST_DROP_GAP        = 16'd13107;
	localparam logic [REG_BITS-1:0]   RST_REAL_THRESHOLD  = 16'd47186;
	localparam logic [REG_BITS-1:0]   RST_SPOOF_THRESHOLD = 16'd29491;

	typedef struct packed {
		logic [REG_BITS-1:0]   fake_cut;
		logic [REG_BITS-1:0]   swap_prev_high;
		logic [REG_BITS-1:0]   swap_cur_low;
		logic [REG_BITS-1:0]   low_cut;
		logic [LIMIT_BITS-1:0] low_run_limit;
		logic [REG_BITS-1:0]   drop_gap;
		logic [REG_BITS-1:0]   real_threshold;
		logic [REG_BITS-1:0]   spoof_threshold;
	} cfg_t;

	// item operations
	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

	// result classes
	typedef enum logic [1:0] {
		ST_REAL   = 2'd0,
		ST_SPOOF  = 2'd1,
		ST_UNSURE = 2'd2
	} status_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_ACC,
		S_ACC_END,
		S_LOAD_AVG,
		S_DIV,
		S_CHECK,
		S_FIN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic acc_step;
		logic acc_end;
		logic load_avg;
		logic div_step;
		logic load_blend;
		logic set_result;
		logic fin_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_clear;
		logic is_pass;
		logic acc_last;
		logic div_last;
		logic blend_needed;
		logic out_free;
	} stat_t;

	// start of row n in the weight table, n*(n-1)/2
	localparam logic [6:0] ROW_BASE [0:15] = '{
		7'd0, 7'd0, 7'd1, 7'd3, 7'd6, 7'd10, 7'd15, 7'd21,
		7'd28, 7'd36, 7'd45, 7'd55, 7'd66, 7'd78, 7'd91, 7'd105
	};

	// 1.8^(i/n) in Q12, rows n = 1..15
	localparam logic [WEIGHT_BITS-1:0] WEIGHT_TAB [0:WEIGHT_ENTRIES-1] = '{
		13'd4096,
		13'd4096, 13'd5495,
		13'd4096, 13'd4983, 13'd6061,
		13'd4096, 13'd4744, 13'd5495, 13'd6365,
		13'd4096, 13'd4607, 13'd5182, 13'd5828, 13'd6555,
		13'd4096, 13'd4518, 13'd4983, 13'd5495, 13'd6061, 13'd6685,
		13'd4096, 13'd4455, 13'd4845, 13'd5269, 13'd5731, 13'd6233, 13'd6779,
		13'd4096, 13'd4408, 13'd4744, 13'd5106, 13'd5495, 13'd5914, 13'd6365,
		13'd6851,
		13'd4096, 13'd4372, 13'd4668, 13'd4983, 13'd5319, 13'd5678, 13'd6061,
		13'd6470, 13'd6907,
		13'd4096, 13'd4344, 13'd4607, 13'd4886, 13'd5182, 13'd5495, 13'd5828,
		13'd6181, 13'd6555, 13'd6952,
		13'd4096, 13'd4321, 13'd4558, 13'd4808, 13'd5072, 13'd5350, 13'd5644,
		13'd5954, 13'd6281, 13'd6626, 13'd6989,
		13'd4096, 13'd4302, 13'd4518, 13'd4744, 13'd4983, 13'd5233, 13'd5495,
		13'd5771, 13'd6061, 13'd6365, 13'd6685, 13'd7020,
		13'd4096, 13'd4285, 13'd4484, 13'd4691, 13'd4908, 13'd5135, 13'd5373,
		13'd5621, 13'd5881, 13'd6153, 13'd6438, 13'd6735, 13'd7047,
		13'd4096, 13'd4272, 13'd4455, 13'd4646, 13'd4845, 13'd5053, 13'd5269,
		13'd5495, 13'd5731, 13'd5977, 13'd6233, 13'd6500, 13'd6779, 13'd7070,
		13'd4096, 13'd4260, 13'd4430, 13'd4607, 13'd4791, 13'd4983, 13'd5182,
		13'd5389, 13'd5604, 13'd5828, 13'd6061, 13'd6303, 13'd6555, 13'd6817,
		13'd7089
	};

	// weight of entry i in a history of n entries
	function automatic logic [WEIGHT_BITS-1:0] weight(input logic [3:0] n,
		input logic [3:0] i);
		logic [6:0] idx;
		idx = ROW_BASE[n] + 7'(i);
		if (idx > 7'(WEIGHT_ENTRIES - 1)) begin
			return '0;
		end
		return WEIGHT_TAB[idx];
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/liveness_score_smoother_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// liveness_score_smoother_unit
// Per-frame liveness score smoother with pass-through of fake scores and
// sudden drops, weighted history average, drop blending and classification.
// ----------------------------------------------------------------------------
// One item at a time. A clear item gives no result. A score that passes
// straight through skips the accumulation and the division. A smoothed score
// walks the history, then divides for the average, and divides once more when
// the drop blend applies: the history is walked one entry a cycle through a
// single multiplier, and the average and the blend share one restoring divider
// that yields a quotient bit a cycle. A finished result sits in the output
// register while the next item is already taken; a new result waits only if
// that register is still full. Configuration registers may be written only
// while the block is idle.
// ----------------------------------------------------------------------------
module liveness_score_smoother_unit #(
	parameter int HISTORY_DEPTH = lss_pkg::HISTORY_DEPTH_DEF,
	parameter int SCORE_BITS    = lss_pkg::SCORE_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             operation,
	input  wire logic [SCORE_BITS-1:0]            raw_score,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [SCORE_BITS-1:0]                 smoothed_score,
	output logic [1:0]                            status,
	output logic                                  passed_through,
	input  wire logic                             cfg_wen,
	input  wire logic [lss_pkg::REG_IDX_BITS-1:0] cfg_index,
	input  wire logic [lss_pkg::REG_BITS-1:0]     cfg_wdata
);

	lss_pkg::cfg_t  cfg;
	lss_pkg::cmd_t  cmd;
	lss_pkg::stat_t stat;

	// configuration registers
	lss_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// sequencer
	lss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath
	lss_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.SCORE_BITS    (SCORE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.stat           (stat),
		.operation      (operation),
		.raw_score      (raw_score),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.smoothed_score (smoothed_score),
		.status         (status),
		.passed_through (passed_through)
	);

endmodule
`default_nettype wire

@@ rtl/core/lss_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lss_cfg
// Configuration register file: eight thresholds written through a plain
// write port, held for the datapath.
// ----------------------------------------------------------------------------
module lss_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wen,
	input  wire logic [lss_pkg::REG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [lss_pkg::REG_BITS-1:0]       cfg_wdata,
	output lss_pkg::cfg_t                           cfg
);

	lss_pkg::cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fake_cut        <= lss_pkg::RST_FAKE_CUT;
			cfg_q.swap_prev_high  <= lss_pkg::RST_SWAP_PREV_HIGH;
			cfg_q.swap_cur_low    <= lss_pkg::RST_SWAP_CUR_LOW;
			cfg_q.low_cut         <= lss_pkg::RST_LOW_CUT;
			cfg_q.low_run_limit   <= lss_pkg::RST_LOW_RUN_LIMIT;
			cfg_q.drop_gap        <= lss_pkg::RST_DROP_GAP;
			cfg_q.real_threshold  <= lss_pkg::RST_REAL_THRESHOLD;
			cfg_q.spoof_threshold <= lss_pkg::RST_SPOOF_THRESHOLD;
		end else if (cfg_wen) begin
			case (cfg_index)
				lss_pkg::REG_FAKE_CUT:        cfg_q.fake_cut        <= cfg_wdata;
				lss_pkg::REG_SWAP_PREV_HIGH:  cfg_q.swap_prev_high  <= cfg_wdata;
				lss_pkg::REG_SWAP_CUR_LOW:    cfg_q.swap_cur_low    <= cfg_wdata;
				lss_pkg::REG_LOW_CUT:         cfg_q.low_cut         <= cfg_wdata;
				lss_pkg::REG_LOW_RUN_LIMIT: begin
					cfg_q.low_run_limit <= cfg_wdata[lss_pkg::LIMIT_BITS-1:0];
				end
				lss_pkg::REG_DROP_GAP:        cfg_q.drop_gap        <= cfg_wdata;
				lss_pkg::REG_REAL_THRESHOLD:  cfg_q.real_threshold  <= cfg_wdata;
				lss_pkg::REG_SPOOF_THRESHOLD: cfg_q.spoof_threshold <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

@@ rtl/core/lss_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lss_ctrl
// Sequencer: takes an item; for a smoothed score runs the weighted
// accumulation, the average division and an optional blend division; hands
// each result, also a passed-through score, to the output register.
// ----------------------------------------------------------------------------
module lss_ctrl (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  lss_pkg::stat_t  stat,
	output lss_pkg::cmd_t   cmd
);

	lss_pkg::state_t state_q;
	lss_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lss_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			lss_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					if (stat.is_clear) begin
						state_d = lss_pkg::S_IDLE;
					end else if (stat.is_pass) begin
						state_d = lss_pkg::S_FIN;
					end else begin
						state_d = lss_pkg::S_ACC;
					end
				end
			end
			lss_pkg::S_ACC: begin
				cmd.acc_step = 1'b1;
				if (stat.acc_last) begin
					state_d = lss_pkg::S_ACC_END;
				end
			end
			lss_pkg::S_ACC_END: begin
				cmd.acc_end = 1'b1;
				state_d     = lss_pkg::S_LOAD_AVG;
			end
			lss_pkg::S_LOAD_AVG: begin
				cmd.load_avg = 1'b1;
				state_d      = lss_pkg::S_DIV;
			end
			lss_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = lss_pkg::S_CHECK;
				end
			end
			lss_pkg::S_CHECK: begin
				if (stat.blend_needed) begin
					cmd.load_blend = 1'b1;
					state_d        = lss_pkg::S_DIV;
				end else begin
					cmd.set_result = 1'b1;
					state_d        = lss_pkg::S_FIN;
				end
			end
			lss_pkg::S_FIN: begin
				if (stat.out_free) begin
					cmd.fin_load = 1'b1;
					state_d      = lss_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lss_pkg::S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/core/lss_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lss_dp
// Datapath: history and run state, weighted accumulator, shared restoring
// divider, classifier and output register.
// ----------------------------------------------------------------------------
module lss_dp #(
	parameter int HISTORY_DEPTH = lss_pkg::HISTORY_DEPTH_DEF,
	parameter int SCORE_BITS    = lss_pkg::SCORE_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  lss_pkg::cfg_t                cfg,
	input  lss_pkg::cmd_t                cmd,
	output lss_pkg::stat_t               stat,
	input  wire logic                    operation,
	input  wire logic [SCORE_BITS-1:0]   raw_score,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [SCORE_BITS-1:0]        smoothed_score,
	output logic [1:0]                   status,
	output logic                         passed_through
);

	localparam int CNT_BITS   = $clog2(HISTORY_DEPTH + 1);
	localparam int IDX_BITS   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int STEP_BITS  = $clog2(SCORE_BITS);
	localparam int CTR_BITS   = (CNT_BITS > STEP_BITS) ? CNT_BITS : STEP_BITS;
	localparam int WSUM_BITS  = lss_pkg::WEIGHT_BITS +
		((HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 0);
	localparam int SUM_BITS   = SCORE_BITS + WSUM_BITS;
	localparam int PROD_BITS  = SCORE_BITS + lss_pkg::WEIGHT_BITS;
	localparam int CMP_BITS   = (SCORE_BITS > lss_pkg::REG_BITS) ? SCORE_BITS :
		lss_pkg::REG_BITS;
	localparam int BLEND_BITS = SCORE_BITS + 4;
	localparam int RUN_MAX    = (1 << lss_pkg::RUN_BITS) - 1;

	// persistent state
	logic [SCORE_BITS-1:0]        hist_q [HISTORY_DEPTH];
	logic [CNT_BITS-1:0]          hcnt_q;
	logic [SCORE_BITS-1:0]        last_q;
	logic [lss_pkg::RUN_BITS-1:0] run_q;

	// per-item working registers
	logic [SCORE_BITS-1:0]        raw_q;
	logic [SCORE_BITS-1:0]        res_q;
	logic                         through_q;
	logic [CTR_BITS-1:0]          cnt_q;
	logic [PROD_BITS-1:0]         prod_s1;
	logic                         pv_s1;
	logic [SUM_BITS-1:0]          sum_q;
	logic [WSUM_BITS-1:0]         wsum_q;
	logic [WSUM_BITS-1:0]         rem_q;
	logic [SCORE_BITS-1:0]        quo_q;
	logic [WSUM_BITS-1:0]         div_q;
	logic                         blended_q;

	// output register
	logic                         out_valid_q;
	logic [SCORE_BITS-1:0]        score_q;
	lss_pkg::status_t             status_q;
	logic                         passed_q;

	// item decode
	logic [CMP_BITS-1:0]          raw_c;
	logic                         is_fake;
	logic                         is_swap;
	logic                         is_low;
	logic [lss_pkg::RUN_BITS-1:0] run_inc;
	logic                         restart;
	logic [CNT_BITS-1:0]          base_cnt;
	logic                         full;

	always_comb begin
		raw_c   = CMP_BITS'(raw_score);
		is_fake = raw_c < CMP_BITS'(cfg.fake_cut);
		is_swap = (CMP_BITS'(last_q) > CMP_BITS'(cfg.swap_prev_high)) &&
			(raw_c < CMP_BITS'(cfg.swap_cur_low));
		is_low  = raw_c < CMP_BITS'(cfg.low_cut);
		run_inc = (run_q == lss_pkg::RUN_BITS'(RUN_MAX)) ? run_q :
			run_q + lss_pkg::RUN_BITS'(1);
		restart  = is_low && (run_inc >= cfg.low_run_limit);
		base_cnt = restart ? '0 : hcnt_q;
		full     = base_cnt == CNT_BITS'(HISTORY_DEPTH);
	end

	// run state and history count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q <= '0;
			last_q <= '0;
			run_q  <= '0;
		end else if (cmd.take) begin
			if (operation == lss_pkg::OP_CLEAR) begin
				hcnt_q <= '0;
				last_q <= '0;
				run_q  <= '0;
			end else if (is_fake) begin
				hcnt_q <= CNT_BITS'(1);
				last_q <= raw_score;
				run_q  <= run_inc;
			end else if (is_swap) begin
				hcnt_q <= '0;
				last_q <= raw_score;
				run_q  <= '0;
			end else begin
				hcnt_q <= full ? CNT_BITS'(HISTORY_DEPTH) : base_cnt + CNT_BITS'(1);
				last_q <= raw_score;
				run_q  <= is_low ? run_inc : '0;
			end
		end
	end

	// history store, oldest first
	always_ff @(posedge clk) begin
		if (cmd.take && operation != lss_pkg::OP_CLEAR) begin
			if (is_fake) begin
				hist_q[0] <= raw_score;
			end else if (!is_swap) begin
				if (full) begin
					for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
						hist_q[i] <= hist_q[i+1];
					end
					hist_q[HISTORY_DEPTH-1] <= raw_score;
				end else begin
					hist_q[base_cnt[IDX_BITS-1:0]] <= raw_score;
				end
			end
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.take || cmd.load_avg || cmd.load_blend) begin
			cnt_q <= '0;
		end else if (cmd.acc_step || cmd.div_step) begin
			cnt_q <= cnt_q + CTR_BITS'(1);
		end
	end

	// weighted accumulation, product registered before the add
	logic [lss_pkg::WEIGHT_BITS-1:0] w_c;
	logic [SCORE_BITS-1:0]           hist_rd;

	assign w_c     = lss_pkg::weight(4'(hcnt_q), 4'(cnt_q));
	assign hist_rd = hist_q[cnt_q[IDX_BITS-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else if (cmd.take) begin
			pv_s1 <= 1'b0;
		end else if (cmd.acc_step) begin
			pv_s1 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			sum_q  <= '0;
			wsum_q <= '0;
		end else if (cmd.acc_step) begin
			prod_s1 <= PROD_BITS'(hist_rd) * PROD_BITS'(w_c);
			sum_q   <= sum_q + (pv_s1 ? SUM_BITS'(prod_s1) : '0);
			wsum_q  <= wsum_q + WSUM_BITS'(w_c);
		end else if (cmd.acc_end) begin
			sum_q <= sum_q + SUM_BITS'(prod_s1);
		end
	end

	// dividends for the average and the blend
	logic [SUM_BITS-1:0]   dvd_avg;
	logic [BLEND_BITS-1:0] blend_c;
	logic [SUM_BITS-1:0]   dvd_blend;

	always_comb begin
		dvd_avg = sum_q + SUM_BITS'(wsum_q >> 1);
		blend_c = BLEND_BITS'(raw_q) * BLEND_BITS'(lss_pkg::BLEND_RAW_W) +
			BLEND_BITS'(quo_q) * BLEND_BITS'(lss_pkg::BLEND_AVG_W) +
			BLEND_BITS'(lss_pkg::BLEND_ROUND);
		dvd_blend = SUM_BITS'(blend_c);
	end

	// restoring divider, one quotient bit per cycle
	logic [WSUM_BITS:0] trial;
	logic [WSUM_BITS:0] diff;
	logic               ge;

	always_comb begin
		trial = {rem_q, quo_q[SCORE_BITS-1]};
		diff  = trial - {1'b0, div_q};
		ge    = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.load_avg) begin
			rem_q <= dvd_avg[SUM_BITS-1:SCORE_BITS];
			quo_q <= dvd_avg[SCORE_BITS-1:0];
			div_q <= wsum_q;
		end else if (cmd.load_blend) begin
			rem_q <= dvd_blend[SUM_BITS-1:SCORE_BITS];
			quo_q <= dvd_blend[SCORE_BITS-1:0];
			div_q <= WSUM_BITS'(lss_pkg::BLEND_DEN);
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[WSUM_BITS-1:0] : trial[WSUM_BITS-1:0];
			quo_q <= {quo_q[SCORE_BITS-2:0], ge};
		end
	end

	// blend pass marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blended_q <= 1'b0;
		end else if (cmd.take) begin
			blended_q <= 1'b0;
		end else if (cmd.load_blend) begin
			blended_q <= 1'b1;
		end
	end

	// item payload and result
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			raw_q     <= raw_score;
			res_q     <= raw_score;
			through_q <= is_fake || is_swap;
		end else if (cmd.set_result) begin
			res_q <= quo_q;
		end
	end

	// large drop test against the average
	logic drop_c;

	assign drop_c = ({1'b0, CMP_BITS'(raw_q)} + (CMP_BITS + 1)'(cfg.drop_gap)) <
		(CMP_BITS + 1)'(quo_q);

	// classification
	lss_pkg::status_t cls_c;

	always_comb begin
		if (CMP_BITS'(res_q) > CMP_BITS'(cfg.real_threshold)) begin
			cls_c = lss_pkg::ST_REAL;
		end else if (CMP_BITS'(res_q) < CMP_BITS'(cfg.spoof_threshold)) begin
			cls_c = lss_pkg::ST_SPOOF;
		end else begin
			cls_c = lss_pkg::ST_UNSURE;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_load) begin
			score_q  <= res_q;
			status_q <= cls_c;
			passed_q <= through_q;
		end
	end

	// status to the controller
	always_comb begin
		stat.is_clear     = operation == lss_pkg::OP_CLEAR;
		stat.is_pass      = is_fake || is_swap;
		stat.acc_last     = CNT_BITS'(cnt_q) == hcnt_q - CNT_BITS'(1);
		stat.div_last     = cnt_q == CTR_BITS'(SCORE_BITS - 1);
		stat.blend_needed = !blended_q && drop_c;
		stat.out_free     = !out_valid_q || out_ready;
	end

	assign out_valid      = out_valid_q;
	assign smoothed_score = score_q;
	assign status         = status_q;
	assign passed_through = passed_q;

endmodule
`default_nettype wire
